### sv/ipsv_pkg.sv
`default_nettype none

package ipsv_pkg;

  localparam int ANGLE_W    = 17;
  localparam int ERR_W      = 18;
  localparam int GAIN_W     = 18;
  localparam int BAND_W     = 15;
  localparam int SCALE_W    = 8;
  localparam int DUTY_W     = 13;
  localparam int CMD_W      = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 18;

  localparam int DIFF_W  = ERR_W + 2;
  localparam int PROD_W  = GAIN_W + 1 + DIFF_W;
  localparam int ACC_W   = PROD_W + 2;
  localparam int SPROD_W = ACC_W + SCALE_W + 1;
  localparam int SUM_W   = SPROD_W + 1;

  localparam int ANGLE_FRAC_BITS_DEF = 8;
  localparam int GAIN_FRAC_BITS_DEF  = 16;

  localparam logic [GAIN_W-1:0]  GAIN_P_RST         = 18'd655;
  localparam logic [GAIN_W-1:0]  GAIN_I_RST         = 18'd26214;
  localparam logic [GAIN_W-1:0]  GAIN_D_RST         = 18'd1311;
  localparam logic [BAND_W-1:0]  DEAD_BAND_RST      = 15'd77;
  localparam logic [BAND_W-1:0]  COMMAND_WINDOW_RST = 15'd2048;
  localparam logic [SCALE_W-1:0] DUTY_SCALE_RST     = 8'd25;
  localparam logic [DUTY_W-1:0]  DUTY_LOW_RST       = 13'd200;
  localparam logic [DUTY_W-1:0]  DUTY_HIGH_RST      = 13'd600;
  localparam logic [DUTY_W-1:0]  DUTY_RST           = 13'd400;

  localparam logic signed [CMD_W-1:0] CMD_MAX = 16'sh7FFF;
  localparam logic signed [CMD_W-1:0] CMD_MIN = 16'sh8000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GAIN_P,
    REG_GAIN_I,
    REG_GAIN_D,
    REG_DEAD_BAND,
    REG_COMMAND_WINDOW,
    REG_DUTY_SCALE,
    REG_DUTY_LOW,
    REG_DUTY_HIGH
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_P,
    ST_MUL_I,
    ST_MUL_D,
    ST_SCALE,
    ST_APPLY
  } state_t;

  typedef enum logic [1:0] {
    TERM_P,
    TERM_I,
    TERM_D
  } term_t;

  typedef struct packed {
    logic [GAIN_W-1:0]  gain_p;
    logic [GAIN_W-1:0]  gain_i;
    logic [GAIN_W-1:0]  gain_d;
    logic [BAND_W-1:0]  dead_band;
    logic [BAND_W-1:0]  command_window;
    logic [SCALE_W-1:0] duty_scale;
    logic [DUTY_W-1:0]  duty_low;
    logic [DUTY_W-1:0]  duty_high;
  } cfg_t;

  typedef struct packed {
    logic  load;
    logic  mul_en;
    term_t term;
    logic  scale_en;
    logic  apply;
  } ctrl_t;

endpackage

`default_nettype wire

### sv/ipsv_in_if.sv
`default_nettype none

interface ipsv_in_if;
  logic                                    valid;
  logic                                    ready;
  logic signed [ipsv_pkg::ANGLE_W-1:0]     roll_measured;
  logic signed [ipsv_pkg::ANGLE_W-1:0]     pitch_measured;
  logic signed [ipsv_pkg::ANGLE_W-1:0]     roll_target;
  logic signed [ipsv_pkg::ANGLE_W-1:0]     pitch_target;

  modport source (
    output valid, roll_measured, pitch_measured, roll_target, pitch_target,
    input  ready
  );
  modport sink (
    input  valid, roll_measured, pitch_measured, roll_target, pitch_target,
    output ready
  );
endinterface

`default_nettype wire

### sv/ipsv_out_if.sv
`default_nettype none

interface ipsv_out_if;
  logic                                valid;
  logic                                ready;
  logic [ipsv_pkg::DUTY_W-1:0]         duty_roll;
  logic [ipsv_pkg::DUTY_W-1:0]         duty_pitch;
  logic                                roll_updated;
  logic                                pitch_updated;
  logic signed [ipsv_pkg::CMD_W-1:0]   roll_command;
  logic signed [ipsv_pkg::CMD_W-1:0]   pitch_command;

  modport source (
    output valid, duty_roll, duty_pitch, roll_updated, pitch_updated,
           roll_command, pitch_command,
    input  ready
  );
  modport sink (
    input  valid, duty_roll, duty_pitch, roll_updated, pitch_updated,
           roll_command, pitch_command,
    output ready
  );
endinterface

`default_nettype wire

### sv/ipsv_lane.sv
`default_nettype none

module ipsv_lane #(
  parameter int ANGLE_FRAC_BITS = ipsv_pkg::ANGLE_FRAC_BITS_DEF,
  parameter int GAIN_FRAC_BITS  = ipsv_pkg::GAIN_FRAC_BITS_DEF
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire ipsv_pkg::ctrl_t                      ctrl,
  input  wire ipsv_pkg::cfg_t                       cfg,
  input  wire logic signed [ipsv_pkg::ANGLE_W-1:0]  measured,
  input  wire logic signed [ipsv_pkg::ANGLE_W-1:0]  target,
  output logic [ipsv_pkg::DUTY_W-1:0]               duty_nxt,
  output logic                                      updated,
  output logic signed [ipsv_pkg::CMD_W-1:0]         command
);

  localparam int ERR_W   = ipsv_pkg::ERR_W;
  localparam int DIFF_W  = ipsv_pkg::DIFF_W;
  localparam int GAIN_W  = ipsv_pkg::GAIN_W;
  localparam int PROD_W  = ipsv_pkg::PROD_W;
  localparam int ACC_W   = ipsv_pkg::ACC_W;
  localparam int SPROD_W = ipsv_pkg::SPROD_W;
  localparam int SUM_W   = ipsv_pkg::SUM_W;
  localparam int DUTY_W  = ipsv_pkg::DUTY_W;
  localparam int CMD_W   = ipsv_pkg::CMD_W;
  localparam int BAND_W  = ipsv_pkg::BAND_W;
  localparam int DUTY_SH = ANGLE_FRAC_BITS + GAIN_FRAC_BITS;

  logic signed [ERR_W-1:0]   last_r, before_r;
  logic signed [DIFF_W-1:0]  diff_p_r, diff_i_r, diff_d_r;
  logic signed [ACC_W-1:0]   acc_r;
  logic signed [SPROD_W-1:0] sprod_r;
  logic                      upd_r;
  logic signed [CMD_W-1:0]   cmd_r;
  logic [DUTY_W-1:0]         duty_r;

  logic signed [ERR_W-1:0]   err;
  logic signed [GAIN_W:0]    op_gain;
  logic signed [DIFF_W-1:0]  op_diff;
  logic signed [PROD_W-1:0]  prod;
  logic [ACC_W-1:0]          mag, qmag, qneg, thr_db, thr_win;
  logic                      in_window;
  logic signed [CMD_W-1:0]   cmd_nxt;
  logic signed [SPROD_W-1:0] sprod_nxt;
  logic [SPROD_W-1:0]        smag, dmag;
  logic signed [SPROD_W-1:0] delta;
  logic signed [SUM_W-1:0]   sum, lim_hi, lim_lo;
  logic [DUTY_W-1:0]         clamped;

  assign err = ERR_W'(measured) - ERR_W'(target);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_r   <= '0;
      before_r <= '0;
      duty_r   <= ipsv_pkg::DUTY_RST;
    end else begin
      if (ctrl.load) begin
        last_r   <= err;
        before_r <= last_r;
      end
      if (ctrl.apply) begin
        duty_r <= duty_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      diff_p_r <= DIFF_W'(err) - DIFF_W'(last_r);
      diff_i_r <= DIFF_W'(err);
      diff_d_r <= DIFF_W'(err) - (DIFF_W'(last_r) <<< 1) + DIFF_W'(before_r);
      acc_r    <= '0;
    end else if (ctrl.mul_en) begin
      acc_r <= acc_r + ACC_W'(prod);
    end
    if (ctrl.scale_en) begin
      sprod_r <= sprod_nxt;
      upd_r   <= in_window;
      cmd_r   <= cmd_nxt;
    end
  end

  always_comb begin
    case (ctrl.term)
      ipsv_pkg::TERM_P: begin
        op_gain = $signed({1'b0, cfg.gain_p});
        op_diff = diff_p_r;
      end
      ipsv_pkg::TERM_I: begin
        op_gain = $signed({1'b0, cfg.gain_i});
        op_diff = diff_i_r;
      end
      ipsv_pkg::TERM_D: begin
        op_gain = $signed({1'b0, cfg.gain_d});
        op_diff = diff_d_r;
      end
      default: begin
        op_gain = '0;
        op_diff = '0;
      end
    endcase
  end

  assign prod = op_gain * op_diff;

  assign mag     = acc_r[ACC_W-1] ? unsigned'(-acc_r) : unsigned'(acc_r);
  assign thr_db  = {{(ACC_W-BAND_W){1'b0}}, cfg.dead_band} << GAIN_FRAC_BITS;
  assign thr_win = {{(ACC_W-BAND_W){1'b0}}, cfg.command_window} << GAIN_FRAC_BITS;
  assign in_window = (mag > thr_db) && (mag <= thr_win);

  assign qmag = mag >> GAIN_FRAC_BITS;
  assign qneg = '0 - qmag;

  always_comb begin
    if (acc_r[ACC_W-1]) begin
      if (qmag > ACC_W'(unsigned'(32'd32768))) begin
        cmd_nxt = ipsv_pkg::CMD_MIN;
      end else begin
        cmd_nxt = signed'(qneg[CMD_W-1:0]);
      end
    end else begin
      if (qmag > ACC_W'(unsigned'(32'd32767))) begin
        cmd_nxt = ipsv_pkg::CMD_MAX;
      end else begin
        cmd_nxt = signed'(qmag[CMD_W-1:0]);
      end
    end
  end

  assign sprod_nxt = acc_r * $signed({1'b0, cfg.duty_scale});

  assign smag  = sprod_r[SPROD_W-1] ? unsigned'(-sprod_r) : unsigned'(sprod_r);
  assign dmag  = smag >> DUTY_SH;
  assign delta = sprod_r[SPROD_W-1] ? -signed'(dmag) : signed'(dmag);

  assign sum    = $signed({{(SUM_W-DUTY_W){1'b0}}, duty_r}) + SUM_W'(delta);
  assign lim_hi = $signed({{(SUM_W-DUTY_W){1'b0}}, cfg.duty_high});
  assign lim_lo = $signed({{(SUM_W-DUTY_W){1'b0}}, cfg.duty_low});

  always_comb begin
    if (sum > lim_hi) begin
      clamped = cfg.duty_high;
    end else if (sum < lim_lo) begin
      clamped = cfg.duty_low;
    end else begin
      clamped = sum[DUTY_W-1:0];
    end
  end

  assign duty_nxt = upd_r ? clamped : duty_r;
  assign updated  = upd_r;
  assign command  = cmd_r;

endmodule

`default_nettype wire

### sv/ipsv_ctrl.sv
`default_nettype none

module ipsv_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_fire,
  input  wire logic             out_free,
  output ipsv_pkg::ctrl_t       ctrl,
  output logic                  idle
);

  ipsv_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ipsv_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ipsv_pkg::ST_IDLE: begin
        if (in_fire) begin
          state_nxt = ipsv_pkg::ST_MUL_P;
        end
      end
      ipsv_pkg::ST_MUL_P: state_nxt = ipsv_pkg::ST_MUL_I;
      ipsv_pkg::ST_MUL_I: state_nxt = ipsv_pkg::ST_MUL_D;
      ipsv_pkg::ST_MUL_D: state_nxt = ipsv_pkg::ST_SCALE;
      ipsv_pkg::ST_SCALE: state_nxt = ipsv_pkg::ST_APPLY;
      ipsv_pkg::ST_APPLY: begin
        if (out_free) begin
          state_nxt = ipsv_pkg::ST_IDLE;
        end
      end
      default: state_nxt = ipsv_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl.load     = 1'b0;
    ctrl.mul_en   = 1'b0;
    ctrl.term     = ipsv_pkg::TERM_P;
    ctrl.scale_en = 1'b0;
    ctrl.apply    = 1'b0;
    idle          = 1'b0;
    case (state_r)
      ipsv_pkg::ST_IDLE: begin
        idle      = 1'b1;
        ctrl.load = in_fire;
      end
      ipsv_pkg::ST_MUL_P: begin
        ctrl.mul_en = 1'b1;
        ctrl.term   = ipsv_pkg::TERM_P;
      end
      ipsv_pkg::ST_MUL_I: begin
        ctrl.mul_en = 1'b1;
        ctrl.term   = ipsv_pkg::TERM_I;
      end
      ipsv_pkg::ST_MUL_D: begin
        ctrl.mul_en = 1'b1;
        ctrl.term   = ipsv_pkg::TERM_D;
      end
      ipsv_pkg::ST_SCALE: ctrl.scale_en = 1'b1;
      ipsv_pkg::ST_APPLY: ctrl.apply = out_free;
      default: idle = 1'b0;
    endcase
  end

endmodule

`default_nettype wire

### sv/incremental_pid_servo_two_axis_top.sv
`default_nettype none

// Two-axis incremental PID servo: one request carries measured and requested roll and
// pitch angles, and one result returns both servo duties, their update flags and the
// saturated commands. Each axis has its own lane with one multiplier that steps through
// the proportional, integral and derivative terms, then scales the accumulated sum to a
// duty step and clamps the duty; the two lanes run side by side and the output register
// merges their results. A request is accepted in ST_IDLE, the three gain terms share
// each lane's multiplier in ST_MUL_P, ST_MUL_I and ST_MUL_D, the scaled sum is registered
// in ST_SCALE, and ST_APPLY waits for a free output register, then returns to ST_IDLE.
// A new request is taken while an earlier result still waits in the output register,
// but a result is only moved into that register once the previous one has been taken.
// Configuration registers may be written only while no request is in flight.
module incremental_pid_servo_two_axis_top #(
  parameter int ANGLE_FRAC_BITS = ipsv_pkg::ANGLE_FRAC_BITS_DEF,
  parameter int GAIN_FRAC_BITS  = ipsv_pkg::GAIN_FRAC_BITS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  ipsv_in_if.sink                                  in_ch,
  ipsv_out_if.source                               out_ch,
  input  wire logic                                cfg_we,
  input  wire logic [ipsv_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [ipsv_pkg::CFG_DATA_W-1:0]     cfg_data
);

  ipsv_pkg::cfg_t  cfg_r;
  ipsv_pkg::ctrl_t ctrl;
  logic            idle;
  logic            in_fire;
  logic            out_free;
  logic            out_valid_r;

  logic [ipsv_pkg::DUTY_W-1:0]       roll_duty, pitch_duty;
  logic                              roll_upd, pitch_upd;
  logic signed [ipsv_pkg::CMD_W-1:0] roll_cmd, pitch_cmd;

  logic [ipsv_pkg::DUTY_W-1:0]       duty_roll_r, duty_pitch_r;
  logic                              roll_updated_r, pitch_updated_r;
  logic signed [ipsv_pkg::CMD_W-1:0] roll_command_r, pitch_command_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.gain_p         <= ipsv_pkg::GAIN_P_RST;
      cfg_r.gain_i         <= ipsv_pkg::GAIN_I_RST;
      cfg_r.gain_d         <= ipsv_pkg::GAIN_D_RST;
      cfg_r.dead_band      <= ipsv_pkg::DEAD_BAND_RST;
      cfg_r.command_window <= ipsv_pkg::COMMAND_WINDOW_RST;
      cfg_r.duty_scale     <= ipsv_pkg::DUTY_SCALE_RST;
      cfg_r.duty_low       <= ipsv_pkg::DUTY_LOW_RST;
      cfg_r.duty_high      <= ipsv_pkg::DUTY_HIGH_RST;
    end else if (cfg_we) begin
      case (ipsv_pkg::reg_idx_t'(cfg_index))
        ipsv_pkg::REG_GAIN_P:    cfg_r.gain_p    <= cfg_data;
        ipsv_pkg::REG_GAIN_I:    cfg_r.gain_i    <= cfg_data;
        ipsv_pkg::REG_GAIN_D:    cfg_r.gain_d    <= cfg_data;
        ipsv_pkg::REG_DEAD_BAND: cfg_r.dead_band <= cfg_data[ipsv_pkg::BAND_W-1:0];
        ipsv_pkg::REG_COMMAND_WINDOW: begin
          cfg_r.command_window <= cfg_data[ipsv_pkg::BAND_W-1:0];
        end
        ipsv_pkg::REG_DUTY_SCALE: cfg_r.duty_scale <= cfg_data[ipsv_pkg::SCALE_W-1:0];
        ipsv_pkg::REG_DUTY_LOW:   cfg_r.duty_low   <= cfg_data[ipsv_pkg::DUTY_W-1:0];
        ipsv_pkg::REG_DUTY_HIGH:  cfg_r.duty_high  <= cfg_data[ipsv_pkg::DUTY_W-1:0];
        default: cfg_r <= cfg_r;
      endcase
    end
  end

  assign in_ch.ready = idle;
  assign in_fire     = in_ch.valid && idle;
  assign out_free    = !out_valid_r || out_ch.ready;

  ipsv_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_fire  (in_fire),
    .out_free (out_free),
    .ctrl     (ctrl),
    .idle     (idle)
  );

  ipsv_lane #(
    .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS),
    .GAIN_FRAC_BITS  (GAIN_FRAC_BITS)
  ) u_lane_roll (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctrl     (ctrl),
    .cfg      (cfg_r),
    .measured (in_ch.roll_measured),
    .target   (in_ch.roll_target),
    .duty_nxt (roll_duty),
    .updated  (roll_upd),
    .command  (roll_cmd)
  );

  ipsv_lane #(
    .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS),
    .GAIN_FRAC_BITS  (GAIN_FRAC_BITS)
  ) u_lane_pitch (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctrl     (ctrl),
    .cfg      (cfg_r),
    .measured (in_ch.pitch_measured),
    .target   (in_ch.pitch_target),
    .duty_nxt (pitch_duty),
    .updated  (pitch_upd),
    .command  (pitch_cmd)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctrl.apply) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.apply) begin
      duty_roll_r     <= roll_duty;
      duty_pitch_r    <= pitch_duty;
      roll_updated_r  <= roll_upd;
      pitch_updated_r <= pitch_upd;
      roll_command_r  <= roll_cmd;
      pitch_command_r <= pitch_cmd;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.duty_roll     = duty_roll_r;
  assign out_ch.duty_pitch    = duty_pitch_r;
  assign out_ch.roll_updated  = roll_updated_r;
  assign out_ch.pitch_updated = pitch_updated_r;
  assign out_ch.roll_command  = roll_command_r;
  assign out_ch.pitch_command = pitch_command_r;

endmodule

`default_nettype wire

### sv/ipsv_checker.sv
`default_nettype none

module ipsv_checker (
  input wire logic                                clk,
  input wire logic                                rst_n,
  input wire logic                                in_valid,
  input wire logic                                in_ready,
  input wire logic                                out_valid,
  input wire logic                                out_ready,
  input wire logic [ipsv_pkg::DUTY_W-1:0]         duty_roll,
  input wire logic [ipsv_pkg::DUTY_W-1:0]         duty_pitch,
  input wire logic                                roll_updated,
  input wire logic                                pitch_updated,
  input wire logic signed [ipsv_pkg::CMD_W-1:0]   roll_command,
  input wire logic signed [ipsv_pkg::CMD_W-1:0]   pitch_command
);

  a_busy_after_request: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n && in_valid && in_ready |=> !in_ready ##1 !in_ready)
    else $error("request accepted while the previous one was still in progress");

  a_result_follows_request: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n && in_valid && in_ready |-> ##[1:6] out_valid)
    else $error("no result presented after an accepted request");

  a_stalled_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n && out_valid && !out_ready |=>
      out_valid && $stable(duty_roll) && $stable(duty_pitch) &&
      $stable(roll_updated) && $stable(pitch_updated) &&
      $stable(roll_command) && $stable(pitch_command))
    else $error("stalled result changed or was dropped");

endmodule

bind incremental_pid_servo_two_axis_top ipsv_checker u_ipsv_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_ch.valid),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .duty_roll     (out_ch.duty_roll),
  .duty_pitch    (out_ch.duty_pitch),
  .roll_updated  (out_ch.roll_updated),
  .pitch_updated (out_ch.pitch_updated),
  .roll_command  (out_ch.roll_command),
  .pitch_command (out_ch.pitch_command)
);

`default_nettype wire
